>>> rtl/salc_pkg.sv
// salc_pkg: shared constants, codes, handshake structs and the saturating add
// for the set-associative lru cache model. no dependencies.
package salc_pkg;

   localparam int MAX_SET_BITS_DEF = 6;
   localparam int MAX_WAYS_DEF     = 8;

   localparam int ADDR_W     = 64;
   localparam int STAMP_W    = 64;
   localparam int CNT_W      = 32;
   localparam int OP_W       = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 6;

   localparam logic [OP_W-1:0] OP_MODIFY = 2'd2;
   localparam logic [OP_W-1:0] OP_OTHER  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_SET_BITS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WAYS     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET   = 2'd2;

   typedef struct packed {
      logic clear;
      logic en;
      logic last;
   } scan_ctl_type;

   typedef struct packed {
      logic found;
      logic empty_vld;
      logic done;
   } scan_sts_type;

   function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] v,
                                                input logic [1:0]       inc);
      logic [CNT_W:0] sum;
      sum = {1'b0, v} + {{(CNT_W-1){1'b0}}, inc};
      return sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
   endfunction

endpackage

>>> rtl/salc_line_mem.sv
// salc_line_mem: tag and last-use memories indexed by {set, way}, plus a
// memory of per-set valid rows. depends on salc_pkg.
module salc_line_mem
   import salc_pkg::*;
#(
   parameter int SET_W = 6,
   parameter int WAY_W = 3
) (
   input  logic                  clock,
   input  logic [SET_W-1:0]      rd_set,
   input  logic [WAY_W-1:0]      rd_way,
   output logic [ADDR_W-1:0]     tag_q,
   output logic [STAMP_W-1:0]    stamp_q,
   output logic [2**WAY_W-1:0]   row_q,
   input  logic [SET_W-1:0]      wr_set,
   input  logic [WAY_W-1:0]      wr_way,
   input  logic                  stamp_we,
   input  logic [STAMP_W-1:0]    stamp_wd,
   input  logic                  tag_we,
   input  logic [ADDR_W-1:0]     tag_wd,
   input  logic                  row_we,
   input  logic [2**WAY_W-1:0]   row_wd
);

   localparam int LINES = 2**(SET_W + WAY_W);
   localparam int SETS  = 2**SET_W;

   logic [ADDR_W-1:0]   tag_mem   [LINES];
   logic [STAMP_W-1:0]  stamp_mem [LINES];
   logic [2**WAY_W-1:0] row_mem   [SETS];

   always_ff @(posedge clock) begin
      if (tag_we) begin
         tag_mem[{wr_set, wr_way}] <= tag_wd;
      end
      tag_q <= tag_mem[{rd_set, rd_way}];
   end

   always_ff @(posedge clock) begin
      if (stamp_we) begin
         stamp_mem[{wr_set, wr_way}] <= stamp_wd;
      end
      stamp_q <= stamp_mem[{rd_set, rd_way}];
   end

   always_ff @(posedge clock) begin
      if (row_we) begin
         row_mem[wr_set] <= row_wd;
      end
      row_q <= row_mem[rd_set];
   end

endmodule

>>> rtl/salc_scan.sv
// salc_scan: shared compare unit, one way per cycle: tag match, empty way
// tracking and running minimum of last-use stamps. depends on salc_pkg.
module salc_scan
   import salc_pkg::*;
#(
   parameter int WAY_W = 3
) (
   input  logic                 clock,
   input  logic                 reset,
   input  scan_ctl_type         ctl,
   input  logic [WAY_W-1:0]     way,
   input  logic                 line_vld,
   input  logic [ADDR_W-1:0]    tag_q,
   input  logic [ADDR_W-1:0]    tag_ref,
   input  logic [STAMP_W-1:0]   stamp_q,
   output scan_sts_type         sts,
   output logic [WAY_W-1:0]     hit_way,
   output logic [WAY_W-1:0]     empty_way,
   output logic [WAY_W-1:0]     lru_way
);

   logic               found_ff, found_in;
   logic               empty_vld_ff, empty_vld_in;
   logic               first_ff, first_in;
   logic [WAY_W-1:0]   hit_way_ff, hit_way_in;
   logic [WAY_W-1:0]   empty_way_ff, empty_way_in;
   logic [WAY_W-1:0]   lru_way_ff, lru_way_in;
   logic [STAMP_W-1:0] min_stamp_ff, min_stamp_in;
   logic               match;
   logic               older;

   assign match = line_vld && (tag_q == tag_ref);
   assign older = stamp_q < min_stamp_ff;

   always_comb begin
      found_in     = found_ff;
      empty_vld_in = empty_vld_ff;
      first_in     = first_ff;
      hit_way_in   = hit_way_ff;
      empty_way_in = empty_way_ff;
      lru_way_in   = lru_way_ff;
      min_stamp_in = min_stamp_ff;
      if (ctl.clear) begin
         found_in     = 1'b0;
         empty_vld_in = 1'b0;
         first_in     = 1'b1;
      end else if (ctl.en && !found_ff) begin
         if (match) begin
            found_in   = 1'b1;
            hit_way_in = way;
         end else if (!line_vld) begin
            empty_vld_in = 1'b1;
            empty_way_in = way;
         end
         // strict compare keeps the lowest way on a tie
         if (first_ff || older) begin
            first_in     = 1'b0;
            min_stamp_in = stamp_q;
            lru_way_in   = way;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff     <= 1'b0;
         empty_vld_ff <= 1'b0;
         first_ff     <= 1'b1;
      end else begin
         found_ff     <= found_in;
         empty_vld_ff <= empty_vld_in;
         first_ff     <= first_in;
      end
      hit_way_ff   <= hit_way_in;
      empty_way_ff <= empty_way_in;
      lru_way_ff   <= lru_way_in;
      min_stamp_ff <= min_stamp_in;
   end

   assign sts.found     = found_ff;
   assign sts.empty_vld = empty_vld_ff;
   assign sts.done      = ctl.en && (ctl.last || match);
   assign hit_way       = hit_way_ff;
   assign empty_way     = empty_way_ff;
   assign lru_way       = lru_way_ff;

endmodule

>>> rtl/set_assoc_lru_cache_sim.sv
// set_assoc_lru_cache_sim: top level, sequencer, address split, counters.
// depends on salc_pkg, salc_line_mem and salc_scan.
//
//   channel   ports                          handshake
//   request   req_opcode, req_address        start & !busy
//   response  rsp_was_*, rsp_*_total         rsp_valid, one cycle, no stall
//   config    csr_index, csr_wdata           csr_we, taken at once
//
// an ignored opcode is answered with busy staying low; a load, store or
// modify keeps busy high while one way per cycle is read from the line memory
// with its compare in the following cycle, until a hit or the last way in use,
// then the write-back state writes the line and updates the counters.
// the response strobe comes the cycle after the last busy cycle.
// after reset a clearing pass zeroes every valid row, with busy high;
// configuration writes are taken meanwhile.
// the receiver cannot stall responses.
module set_assoc_lru_cache_sim
   import salc_pkg::*;
#(
   parameter int MAX_SET_BITS = MAX_SET_BITS_DEF,
   parameter int MAX_WAYS     = MAX_WAYS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [OP_W-1:0]       req_opcode,
   input  logic [ADDR_W-1:0]     req_address,
   output logic                  rsp_valid,
   output logic                  rsp_was_hit,
   output logic                  rsp_was_miss,
   output logic                  rsp_was_eviction,
   output logic                  rsp_write_back_hit,
   output logic [CNT_W-1:0]      rsp_hit_total,
   output logic [CNT_W-1:0]      rsp_miss_total,
   output logic [CNT_W-1:0]      rsp_eviction_total,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
   localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int ROW_W = 2**WAY_W;

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_SCAN  = 2'd2;
   localparam logic [1:0] ST_WRITE = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [SET_W-1:0]    clr_idx_ff, clr_idx_in;
   logic [2:0]          cfg_sets_ff;
   logic [3:0]          cfg_ways_ff;
   logic [5:0]          cfg_off_ff;
   logic [SET_W-1:0]    set_ff, set_in;
   logic [ADDR_W-1:0]   tag_ff, tag_in;
   logic [STAMP_W-1:0]  now_ff, now_in;
   logic                modify_ff, modify_in;
   logic [STAMP_W-1:0]  clock_ff, clock_in;
   logic [WAY_W-1:0]    rd_way_ff, rd_way_in;
   logic                rd_done_ff, rd_done_in;
   logic                cmp_en_ff, cmp_en_in;
   logic [WAY_W-1:0]    cmp_way_ff, cmp_way_in;
   logic [CNT_W-1:0]    hits_ff, hits_in;
   logic [CNT_W-1:0]    misses_ff, misses_in;
   logic [CNT_W-1:0]    evicts_ff, evicts_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_hit_ff, rsp_hit_in;
   logic                rsp_miss_ff, rsp_miss_in;
   logic                rsp_evict_ff, rsp_evict_in;
   logic                rsp_wb_ff, rsp_wb_in;

   logic                accept;
   logic [2:0]          sb_eff;
   logic [6:0]          tshift;
   logic [ADDR_W-1:0]   set_mask;
   logic [ADDR_W-1:0]   set_full;
   logic [5:0]          ways_eff;
   logic [WAY_W-1:0]    last_way;
   logic                rd_en;

   logic [ADDR_W-1:0]   tag_q;
   logic [STAMP_W-1:0]  stamp_q;
   logic [ROW_W-1:0]    row_q;
   logic [SET_W-1:0]    wr_set;
   logic [WAY_W-1:0]    wr_way;
   logic                stamp_we;
   logic                tag_we;
   logic                row_we;
   logic [ROW_W-1:0]    row_wd;

   scan_ctl_type        scan_ctl;
   scan_sts_type        scan_sts;
   logic [WAY_W-1:0]    hit_way;
   logic [WAY_W-1:0]    empty_way;
   logic [WAY_W-1:0]    lru_way;
   logic [WAY_W-1:0]    victim;
   logic [ROW_W-1:0]    victim_bit;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_sets_ff <= 3'd0;
         cfg_ways_ff <= 4'd1;
         cfg_off_ff  <= 6'd0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SET_BITS: cfg_sets_ff <= csr_wdata[2:0];
            CSR_WAYS:     cfg_ways_ff <= csr_wdata[3:0];
            CSR_OFFSET:   cfg_off_ff  <= csr_wdata;
            default:      ;
         endcase
      end
   end

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // address split
   always_comb begin
      sb_eff   = (32'(cfg_sets_ff) > MAX_SET_BITS) ? 3'(MAX_SET_BITS) : cfg_sets_ff;
      tshift   = {4'd0, sb_eff} + {1'b0, cfg_off_ff};
      set_mask = (ADDR_W'(1) << sb_eff) - ADDR_W'(1);
      set_full = (req_address >> cfg_off_ff) & set_mask;
      tag_in   = (tshift >= 7'd64) ? '0 : (req_address >> tshift);
      set_in   = set_full[SET_W-1:0];
   end

   always_comb begin
      if (cfg_ways_ff == 4'd0) begin
         ways_eff = 6'd1;
      end else if (32'(cfg_ways_ff) > MAX_WAYS) begin
         ways_eff = 6'(MAX_WAYS);
      end else begin
         ways_eff = {2'b0, cfg_ways_ff};
      end
      last_way = WAY_W'(ways_eff - 6'd1);
   end

   assign rd_en = (state_ff == ST_SCAN) && !rd_done_ff;

   always_comb begin
      victim = scan_sts.found ? hit_way : (scan_sts.empty_vld ? empty_way : lru_way);
      victim_bit = ROW_W'(1) << victim;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clr_idx_in   = clr_idx_ff;
      now_in       = now_ff;
      modify_in    = modify_ff;
      clock_in     = clock_ff;
      rd_way_in    = rd_way_ff;
      rd_done_in   = rd_done_ff;
      cmp_en_in    = rd_en;
      cmp_way_in   = rd_way_ff;
      hits_in      = hits_ff;
      misses_in    = misses_ff;
      evicts_in    = evicts_ff;
      rsp_valid_in = 1'b0;
      rsp_hit_in   = rsp_hit_ff;
      rsp_miss_in  = rsp_miss_ff;
      rsp_evict_in = rsp_evict_ff;
      rsp_wb_in    = rsp_wb_ff;
      scan_ctl     = '{clear: 1'b0, en: 1'b0, last: 1'b0};
      stamp_we     = 1'b0;
      tag_we       = 1'b0;
      row_we       = 1'b0;
      row_wd       = row_q | victim_bit;
      wr_set       = set_ff;
      wr_way       = victim;

      case (state_ff)
         ST_CLEAR: begin
            row_we     = 1'b1;
            row_wd     = '0;
            wr_set     = clr_idx_ff;
            clr_idx_in = clr_idx_ff + SET_W'(1);
            if (clr_idx_ff == {SET_W{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               now_in    = clock_ff;
               clock_in  = clock_ff + STAMP_W'(1);
               modify_in = (req_opcode == OP_MODIFY);
               if (req_opcode == OP_OTHER) begin
                  // no lookup, totals reported unchanged
                  rsp_valid_in = 1'b1;
                  rsp_hit_in   = 1'b0;
                  rsp_miss_in  = 1'b0;
                  rsp_evict_in = 1'b0;
                  rsp_wb_in    = 1'b0;
               end else begin
                  state_in       = ST_SCAN;
                  rd_way_in      = '0;
                  rd_done_in     = 1'b0;
                  scan_ctl.clear = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            if (rd_en) begin
               rd_way_in = rd_way_ff + WAY_W'(1);
               if (rd_way_ff == last_way) begin
                  rd_done_in = 1'b1;
               end
            end
            scan_ctl.en   = cmp_en_ff;
            scan_ctl.last = (cmp_way_ff == last_way);
            if (scan_sts.done) begin
               state_in  = ST_WRITE;
               cmp_en_in = 1'b0;
            end
         end
         ST_WRITE: begin
            cmp_en_in = 1'b0;
            stamp_we  = 1'b1;
            tag_we    = !scan_sts.found;
            row_we    = !scan_sts.found;
            hits_in   = sat_add(hits_ff, {1'b0, modify_ff} + {1'b0, scan_sts.found});
            if (!scan_sts.found) begin
               misses_in = sat_add(misses_ff, 2'd1);
               if (!scan_sts.empty_vld) begin
                  evicts_in = sat_add(evicts_ff, 2'd1);
               end
            end
            rsp_valid_in = 1'b1;
            rsp_hit_in   = scan_sts.found;
            rsp_miss_in  = !scan_sts.found;
            rsp_evict_in = !scan_sts.found && !scan_sts.empty_vld;
            rsp_wb_in    = modify_ff;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_idx_ff   <= '0;
         clock_ff     <= '0;
         hits_ff      <= '0;
         misses_ff    <= '0;
         evicts_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         rd_done_ff   <= 1'b1;
         cmp_en_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         clock_ff     <= clock_in;
         hits_ff      <= hits_in;
         misses_ff    <= misses_in;
         evicts_ff    <= evicts_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_done_ff   <= rd_done_in;
         cmp_en_ff    <= cmp_en_in;
      end
      if (accept) begin
         set_ff <= set_in;
         tag_ff <= tag_in;
      end
      now_ff       <= now_in;
      modify_ff    <= modify_in;
      rd_way_ff    <= rd_way_in;
      cmp_way_ff   <= cmp_way_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_miss_ff  <= rsp_miss_in;
      rsp_evict_ff <= rsp_evict_in;
      rsp_wb_ff    <= rsp_wb_in;
   end

   salc_line_mem #(
      .SET_W (SET_W),
      .WAY_W (WAY_W)
   ) u_line_mem (
      .clock    (clock),
      .rd_set   (set_ff),
      .rd_way   (rd_way_ff),
      .tag_q    (tag_q),
      .stamp_q  (stamp_q),
      .row_q    (row_q),
      .wr_set   (wr_set),
      .wr_way   (wr_way),
      .stamp_we (stamp_we),
      .stamp_wd (now_ff),
      .tag_we   (tag_we),
      .tag_wd   (tag_ff),
      .row_we   (row_we),
      .row_wd   (row_wd)
   );

   salc_scan #(
      .WAY_W (WAY_W)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .ctl       (scan_ctl),
      .way       (cmp_way_ff),
      .line_vld  (row_q[cmp_way_ff]),
      .tag_q     (tag_q),
      .tag_ref   (tag_ff),
      .stamp_q   (stamp_q),
      .sts       (scan_sts),
      .hit_way   (hit_way),
      .empty_way (empty_way),
      .lru_way   (lru_way)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_was_hit        = rsp_hit_ff;
   assign rsp_was_miss       = rsp_miss_ff;
   assign rsp_was_eviction   = rsp_evict_ff;
   assign rsp_write_back_hit = rsp_wb_ff;
   assign rsp_hit_total      = hits_ff;
   assign rsp_miss_total     = misses_ff;
   assign rsp_eviction_total = evicts_ff;

endmodule
